// ===== rtl/core/sttm_pkg.sv =====
// shared types and constants for the substation thermal trip model
// no dependencies; imported by every module of the block
`default_nettype none

package sttm_pkg;

    // event kinds carried on the input tuser
    localparam logic [2:0] OP_OTHER       = 3'd0;
    localparam logic [2:0] OP_GRID        = 3'd1;
    localparam logic [2:0] OP_WEATHER     = 3'd2;
    localparam logic [2:0] OP_PROTECTION  = 3'd3;
    localparam logic [2:0] OP_MAINTENANCE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CAPACITY    = 3'd0;
    localparam logic [2:0] REG_TIME_COEF   = 3'd1;
    localparam logic [2:0] REG_RATED_RISE  = 3'd2;
    localparam logic [2:0] REG_TRIP_TEMP   = 3'd3;
    localparam logic [2:0] REG_WARN_TEMP   = 3'd4;
    localparam logic [2:0] REG_REARM_TEMP  = 3'd5;

    // configuration reset values
    localparam logic [15:0] CAPACITY_RST   = 16'd1600;
    localparam logic [15:0] TIME_COEF_RST  = 16'd546;
    localparam logic [14:0] RATED_RISE_RST = 15'd3520;
    localparam logic [15:0] TRIP_TEMP_RST  = 16'd7040;
    localparam logic [15:0] WARN_TEMP_RST  = 16'd6080;
    localparam logic [15:0] REARM_TEMP_RST = 16'd4480;

    // state reset values
    localparam logic [15:0] VOLTAGE_RST    = 16'd16384;
    localparam logic [15:0] CORE_TEMP_RST  = 16'd2560;
    localparam logic [15:0] AMBIENT_RST    = 16'd1600;

    localparam logic [15:0] CAPACITY_MIN   = 16'd16;
    localparam logic [15:0] VOLT_LOW       = 16'd14746;
    localparam logic [15:0] VOLT_STRESS    = 16'd15565;
    localparam logic [16:0] FACTOR_FULL    = 17'd65536;
    localparam logic [16:0] FACTOR_LOW     = 17'd32768;
    localparam logic [16:0] FACTOR_STRESS  = 17'd52429;
    localparam logic [17:0] RATIO_MAX      = 18'd262143;

    // shared unit widths
    localparam int DIV_W   = 32;
    localparam int DVSR_W  = 16;
    localparam int MUL_AW  = 24;
    localparam int MUL_BW  = 19;
    localparam int MUL_PW  = MUL_AW + MUL_BW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_SQ,
        S_RISE_LO,
        S_RISE_HI,
        S_ACC,
        S_GAP,
        S_STEP,
        S_UPDATE,
        S_FACT,
        S_FDIV_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/substation_thermal_trip_model.sv =====
// top level of the substation thermal trip model: state, config, sequencer
// depends on sttm_pkg, sttm_div and sttm_mul
//
// channel        dir  signals                         contents
// event in       in   s_axis_tvalid/tready/tdata/tuser one telemetry event
// result out     out  m_axis_tvalid/tready/tdata       one thermal step result
// config         in   i_cfg_we/i_cfg_addr/i_cfg_data   register writes
//
// when the thermal derate needs the linear falloff a second division follows
// the first; both divisions go through one 32-step divider and the square,
// rise and step products through one registered multiplier
// reset is synchronous, active low, and restores config and state
// the next event is taken once the sequencer is back in idle, while the
// previous result may still wait in the output register; a full output
// register holds the sequencer in its last state
`default_nettype none

module substation_thermal_trip_model
    import sttm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // event in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // load_present, load_value, voltage_present, voltage_value,
    // temperature_present, temperature_value, trip_present, trip_value,
    // maintenance_active, zero pad
    input  wire  [55:0] s_axis_tdata,
    // operation
    input  wire  [2:0]  s_axis_tuser,
    // result out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // core_temperature, tripped, load_ratio, throughput_factor, zero pad
    output logic [55:0] m_axis_tdata,
    // config
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_data
);

    // config
    logic [15:0]        r_capacity;
    logic [15:0]        r_time_coef;
    logic [14:0]        r_rated_rise;
    logic signed [15:0] r_trip_temp;
    logic signed [15:0] r_warn_temp;
    logic signed [15:0] r_rearm_temp;

    // model state
    logic [15:0]        r_load;
    logic [15:0]        r_voltage;
    logic signed [15:0] r_core;
    logic signed [15:0] r_ambient;
    logic               r_trip;
    logic               r_maint;

    // working registers
    t_state             r_state;
    t_state             n_state;
    logic [17:0]        r_ratio;
    logic [35:0]        r_sq;
    logic [51:0]        r_acc;
    logic signed [22:0] r_gap;
    logic [16:0]        r_factor;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_out_temp;
    logic               r_out_trip;
    logic [17:0]        r_out_ratio;
    logic [16:0]        r_out_factor;

    // shared units
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVSR_W-1:0]         div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;
    logic signed [MUL_AW-1:0]  mul_a;
    logic signed [MUL_BW-1:0]  mul_b;
    logic signed [MUL_PW-1:0]  mul_p;

    // input fields
    logic               in_load_p;
    logic [15:0]        in_load_v;
    logic               in_volt_p;
    logic [15:0]        in_volt_v;
    logic               in_temp_p;
    logic signed [15:0] in_temp_v;
    logic               in_trip_p;
    logic               in_trip_v;
    logic               in_maint_v;
    logic               in_accept;

    assign in_load_p  = s_axis_tdata[0];
    assign in_load_v  = s_axis_tdata[16:1];
    assign in_volt_p  = s_axis_tdata[17];
    assign in_volt_v  = s_axis_tdata[33:18];
    assign in_temp_p  = s_axis_tdata[34];
    assign in_temp_v  = s_axis_tdata[50:35];
    assign in_trip_p  = s_axis_tdata[51];
    assign in_trip_v  = s_axis_tdata[52];
    assign in_maint_v = s_axis_tdata[53];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // combinational datapath pieces
    logic [15:0]        cap_eff;
    logic [17:0]        ratio_sat;
    logic signed [22:0] gap_calc;
    logic signed [MUL_PW-1:0] step_sum;
    logic signed [26:0] delta;
    logic signed [27:0] nt_wide;
    logic signed [15:0] nt_sat;
    logic signed [16:0] excess;
    logic signed [16:0] margin;
    logic               derate;
    logic               margin_bad;
    logic [16:0]        fall_factor;
    logic [16:0]        volt_factor;

    always_comb begin
        cap_eff   = (r_capacity < CAPACITY_MIN) ? CAPACITY_MIN : r_capacity;
        ratio_sat = (|div_q[DIV_W-1:18]) ? RATIO_MAX : div_q[17:0];

        gap_calc = {{7{r_ambient[15]}}, r_ambient} + {3'b000, r_acc[51:32]}
                 - {{7{r_core[15]}}, r_core};

        // round to nearest, ties up, then floor shift
        step_sum = mul_p + MUL_PW'(32768);
        delta    = step_sum[42:16];
        nt_wide  = {{12{r_core[15]}}, r_core} + {delta[26], delta};
        if (nt_wide > 28'sd32767) begin
            nt_sat = 16'sh7fff;
        end else if (nt_wide < -28'sd32768) begin
            nt_sat = 16'sh8000;
        end else begin
            nt_sat = nt_wide[15:0];
        end

        excess     = {r_core[15], r_core} - {r_warn_temp[15], r_warn_temp};
        margin     = {r_trip_temp[15], r_trip_temp} - {r_warn_temp[15], r_warn_temp};
        derate     = (r_core > r_warn_temp);
        margin_bad = margin[16] || (margin == 17'sd0);

        if ((|div_q[DIV_W-1:17]) || (div_q[16:0] > FACTOR_FULL)) begin
            fall_factor = '0;
        end else begin
            fall_factor = FACTOR_FULL - div_q[16:0];
        end

        if (r_voltage < VOLT_LOW) begin
            volt_factor = FACTOR_LOW;
        end else if (r_voltage < VOLT_STRESS) begin
            volt_factor = FACTOR_STRESS;
        end else begin
            volt_factor = FACTOR_FULL;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_RDIV_GO;
                end
            end
            S_RDIV_GO:   n_state = S_RDIV_WAIT;
            S_RDIV_WAIT: begin
                if (div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:        n_state = S_RISE_LO;
            S_RISE_LO:   n_state = S_RISE_HI;
            S_RISE_HI:   n_state = S_ACC;
            S_ACC:       n_state = S_GAP;
            S_GAP:       n_state = S_STEP;
            S_STEP:      n_state = S_UPDATE;
            S_UPDATE:    n_state = S_FACT;
            S_FACT: begin
                if (!r_trip && !r_maint && derate && !margin_bad) begin
                    n_state = S_FDIV_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FDIV_WAIT: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // shared unit control
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {r_load, 16'h0000};
        div_divisor  = cap_eff;
        mul_a        = '0;
        mul_b        = '0;
        case (r_state)
            S_RDIV_GO: begin
                div_start = 1'b1;
            end
            S_SQ: begin
                mul_a = {6'b0, r_ratio};
                mul_b = {1'b0, r_ratio};
            end
            S_RISE_LO: begin
                mul_a = {9'b0, r_rated_rise};
                mul_b = {1'b0, mul_p[17:0]};
            end
            S_RISE_HI: begin
                mul_a = {9'b0, r_rated_rise};
                mul_b = {1'b0, r_sq[35:18]};
            end
            S_STEP: begin
                mul_a = {r_gap[22], r_gap};
                mul_b = {3'b000, r_time_coef};
            end
            S_FACT: begin
                div_start    = !r_trip && !r_maint && derate && !margin_bad;
                div_dividend = {excess[15:0], 16'h0000};
                div_divisor  = margin[15:0];
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    sttm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    sttm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RST;
            r_time_coef  <= TIME_COEF_RST;
            r_rated_rise <= RATED_RISE_RST;
            r_trip_temp  <= TRIP_TEMP_RST;
            r_warn_temp  <= WARN_TEMP_RST;
            r_rearm_temp <= REARM_TEMP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CAPACITY:   r_capacity   <= i_cfg_data;
                REG_TIME_COEF:  r_time_coef  <= i_cfg_data;
                REG_RATED_RISE: r_rated_rise <= i_cfg_data[14:0];
                REG_TRIP_TEMP:  r_trip_temp  <= i_cfg_data;
                REG_WARN_TEMP:  r_warn_temp  <= i_cfg_data;
                REG_REARM_TEMP: r_rearm_temp <= i_cfg_data;
                default: begin
                    r_capacity <= r_capacity;
                end
            endcase
        end
    end

    // state, sequencer and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_load    <= '0;
            r_voltage <= VOLTAGE_RST;
            r_core    <= CORE_TEMP_RST;
            r_ambient <= AMBIENT_RST;
            r_trip    <= 1'b0;
            r_maint   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                case (s_axis_tuser)
                    OP_GRID: begin
                        if (in_load_p) r_load    <= in_load_v;
                        if (in_volt_p) r_voltage <= in_volt_v;
                        if (in_temp_p) r_core    <= in_temp_v;
                    end
                    OP_WEATHER: begin
                        if (in_temp_p) r_ambient <= in_temp_v;
                    end
                    OP_PROTECTION: begin
                        if (in_trip_p) r_trip <= in_trip_v;
                    end
                    OP_MAINTENANCE: begin
                        r_maint <= in_maint_v;
                    end
                    default: begin
                        r_maint <= r_maint;
                    end
                endcase
            end
            if (r_state == S_UPDATE) begin
                r_core <= nt_sat;
                // ratio was already taken, so shedding here only affects later steps
                if (nt_sat > r_trip_temp) begin
                    r_trip <= 1'b1;
                    r_load <= '0;
                end else if (r_trip && (nt_sat < r_rearm_temp)) begin
                    r_trip <= 1'b0;
                end
            end
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RDIV_WAIT: begin
                if (div_done) r_ratio <= ratio_sat;
            end
            S_RISE_LO: r_sq <= mul_p[35:0];
            S_RISE_HI: r_acc <= {19'b0, mul_p[32:0]};
            S_ACC:     r_acc <= r_acc + {1'b0, mul_p[32:0], 18'b0} + 52'h0_0000_8000_0000;
            S_GAP:     r_gap <= gap_calc;
            S_FACT: begin
                if (r_trip || r_maint) begin
                    r_factor <= '0;
                end else if (derate) begin
                    r_factor <= '0;
                end else begin
                    r_factor <= volt_factor;
                end
            end
            S_FDIV_WAIT: begin
                if (div_done) r_factor <= fall_factor;
            end
            default: begin
                r_gap <= r_gap;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_temp   <= r_core;
            r_out_trip   <= r_trip;
            r_out_ratio  <= r_ratio;
            r_out_factor <= r_factor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_factor, r_out_ratio, r_out_trip, r_out_temp};

endmodule

`default_nettype wire

// ===== rtl/core/sttm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on sttm_pkg for the operand widths
`default_nettype none

module sttm_div
    import sttm_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [DIV_W-1:0]       i_dividend,
    input  wire [DVSR_W-1:0]      i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_quo;
    logic [DVSR_W-1:0]  r_rem;
    logic [DVSR_W-1:0]  r_dvsr;

    logic [DVSR_W:0]    n_trial;
    logic               n_ge;
    logic [DVSR_W:0]    n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvsr});
        n_diff  = n_trial - {1'b0, r_dvsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits its width
            r_rem <= n_ge ? n_diff[DVSR_W-1:0] : n_trial[DVSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/sttm_mul.sv =====
// shared signed multiplier with a registered product
// depends on sttm_pkg for the operand widths
`default_nettype none

module sttm_mul
    import sttm_pkg::*;
(
    input  wire                        i_clk,
    input  wire signed [MUL_AW-1:0]    i_a,
    input  wire signed [MUL_BW-1:0]    i_b,
    output logic signed [MUL_PW-1:0]   o_p
);

    logic signed [MUL_PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for substation_thermal_trip_model: telemetry requests in,
// thermal step results out, checked against an in-bench thermal predictor
// depends on sttm_pkg and the substation_thermal_trip_model rtl

module testbench;
    import sttm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 800;

    typedef struct {
        logic [2:0]         op;
        logic               load_p;
        logic [15:0]        load_v;
        logic               volt_p;
        logic [15:0]        volt_v;
        logic               temp_p;
        logic signed [15:0] temp_v;
        logic               trip_p;
        logic               trip_v;
        logic               maint;
    } t_telemetry;

    typedef struct {
        logic signed [15:0] core;
        logic               tripped;
        logic [17:0]        ratio;
        logic [16:0]        factor;
    } t_thermal_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = OP_OTHER;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = REG_CAPACITY;
    logic [15:0] i_cfg_data = '0;

    substation_thermal_trip_model i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of configuration and plant state
    logic [15:0]        cfg_capacity = CAPACITY_RST;
    logic [15:0]        cfg_tcoef    = TIME_COEF_RST;
    logic [14:0]        cfg_rise     = RATED_RISE_RST;
    logic signed [15:0] cfg_trip     = TRIP_TEMP_RST;
    logic signed [15:0] cfg_warn     = WARN_TEMP_RST;
    logic signed [15:0] cfg_rearm    = REARM_TEMP_RST;

    logic [15:0]        plant_load    = '0;
    logic [15:0]        plant_volt    = VOLTAGE_RST;
    logic signed [15:0] plant_core    = CORE_TEMP_RST;
    logic signed [15:0] plant_ambient = AMBIENT_RST;
    logic               plant_trip    = 1'b0;
    logic               plant_maint   = 1'b0;

    t_thermal_result expected_steps[$];
    int mismatch_count = 0;
    int events_sent    = 0;
    int steps_checked  = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int cycle_count    = 0;

    // long output hold requests, counted down by the receiver
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_len  = 0;
    int hold_left = 0;
    logic [7:0] rx_phase = '0;
    logic [1:0] rx_mode  = '0;

    function automatic t_thermal_result thermal_step(input t_telemetry ev);
        t_thermal_result r;
        longint cap, ratio, rise, target, gap, delta, nt, margin, excess, factor;
        case (ev.op)
            OP_GRID: begin
                if (ev.load_p) plant_load = ev.load_v;
                if (ev.volt_p) plant_volt = ev.volt_v;
                if (ev.temp_p) plant_core = ev.temp_v;
            end
            OP_WEATHER:     if (ev.temp_p) plant_ambient = ev.temp_v;
            OP_PROTECTION:  if (ev.trip_p) plant_trip = ev.trip_v;
            OP_MAINTENANCE: plant_maint = ev.maint;
            default: ;
        endcase

        cap = (cfg_capacity < CAPACITY_MIN) ? longint'(CAPACITY_MIN) : longint'(cfg_capacity);
        // ratio is taken from the load before any shed in this step
        ratio = (longint'(plant_load) << 16) / cap;
        if (ratio > longint'(RATIO_MAX)) ratio = longint'(RATIO_MAX);
        rise = (longint'(cfg_rise) * ratio * ratio + (longint'(1) << 31)) >>> 32;
        target = longint'(plant_ambient) + rise;
        gap = target - longint'(plant_core);
        // arithmetic shift gives the floor, so ties round toward plus infinity
        delta = (gap * longint'(cfg_tcoef) + 32768) >>> 16;
        nt = longint'(plant_core) + delta;
        if (nt > 32767) nt = 32767;
        if (nt < -32768) nt = -32768;
        plant_core = nt[15:0];

        if (plant_core > cfg_trip) begin
            plant_trip = 1'b1;
            plant_load = '0;
        end else if (plant_trip && plant_core < cfg_rearm) begin
            plant_trip = 1'b0;
        end

        if (plant_trip || plant_maint) begin
            factor = 0;
        end else if (plant_core > cfg_warn) begin
            margin = longint'(cfg_trip) - longint'(cfg_warn);
            if (margin <= 0) begin
                factor = 0;
            end else begin
                excess = longint'(plant_core) - longint'(cfg_warn);
                factor = longint'(FACTOR_FULL) - (excess * 65536) / margin;
                if (factor < 0) factor = 0;
            end
        end else if (plant_volt < VOLT_LOW) begin
            factor = longint'(FACTOR_LOW);
        end else if (plant_volt < VOLT_STRESS) begin
            factor = longint'(FACTOR_STRESS);
        end else begin
            factor = longint'(FACTOR_FULL);
        end

        r.core    = plant_core;
        r.tripped = plant_trip;
        r.ratio   = ratio[17:0];
        r.factor  = factor[16:0];
        return r;
    endfunction

    function automatic logic [15:0] near_temp(input logic signed [15:0] centre, input int span);
        return 16'(int'(centre) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // mostly plausible telemetry around the current thresholds, some full-range noise
    function automatic t_telemetry random_event();
        t_telemetry ev;
        int pick;
        ev.load_p = 1'($urandom_range(0, 1));
        ev.load_v = 16'($urandom);
        ev.volt_p = 1'($urandom_range(0, 1));
        ev.volt_v = 16'($urandom);
        ev.temp_p = 1'($urandom_range(0, 1));
        ev.temp_v = 16'($urandom);
        ev.trip_p = 1'($urandom_range(0, 1));
        ev.trip_v = 1'($urandom_range(0, 1));
        ev.maint  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            ev.op = OP_GRID;
            ev.load_p = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 4) != 0) ev.load_v = 16'($urandom_range(0, 8000));
            if ($urandom_range(0, 4) != 0) ev.volt_v = 16'($urandom_range(14000, 17000));
            ev.temp_p = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) ev.temp_v = near_temp(cfg_warn, 3000);
        end else if (pick < 60) begin
            ev.op = OP_WEATHER;
            ev.temp_p = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 4) != 0) ev.temp_v = near_temp(16'sd1600, 2000);
        end else if (pick < 75) begin
            ev.op = OP_PROTECTION;
            ev.trip_p = ($urandom_range(0, 4) != 0);
        end else if (pick < 85) begin
            ev.op = OP_MAINTENANCE;
            ev.maint = ($urandom_range(0, 9) < 3);
        end else if (pick < 93) begin
            ev.op = OP_OTHER;
        end else begin
            ev.op = 3'($urandom_range(OP_MAINTENANCE + 1, 7));
        end
        return ev;
    endfunction

    // one request, after a random gap when a burst has run out
    task automatic send_event(input t_telemetry ev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.op;
        s_axis_tdata  <= {2'b00, ev.maint, ev.trip_v, ev.trip_p, ev.temp_v, ev.temp_p,
                          ev.volt_v, ev.volt_p, ev.load_v, ev.load_p};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_steps.push_back(thermal_step(ev));
        events_sent++;
    endtask

    task automatic send_grid(input logic lp, input logic [15:0] lv, input logic vp,
                             input logic [15:0] vv, input logic tp, input logic [15:0] tv);
        t_telemetry ev;
        ev = random_event();
        ev.op = OP_GRID;
        ev.load_p = lp;
        ev.load_v = lv;
        ev.volt_p = vp;
        ev.volt_v = vv;
        ev.temp_p = tp;
        ev.temp_v = tv;
        send_event(ev);
    endtask

    task automatic send_weather(input logic tp, input logic [15:0] tv);
        t_telemetry ev;
        ev = random_event();
        ev.op = OP_WEATHER;
        ev.temp_p = tp;
        ev.temp_v = tv;
        send_event(ev);
    endtask

    task automatic send_protection(input logic tp, input logic tv);
        t_telemetry ev;
        ev = random_event();
        ev.op = OP_PROTECTION;
        ev.trip_p = tp;
        ev.trip_v = tv;
        send_event(ev);
    endtask

    task automatic send_op(input logic [2:0] op, input logic maint);
        t_telemetry ev;
        ev = random_event();
        ev.op = op;
        ev.maint = maint;
        send_event(ev);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic load_config(input logic [15:0] cap, tcoef, rise, trip_t, warn_t, rearm_t);
        put_reg(REG_CAPACITY, cap);
        put_reg(REG_TIME_COEF, tcoef);
        put_reg(REG_RATED_RISE, rise);
        put_reg(REG_TRIP_TEMP, trip_t);
        put_reg(REG_WARN_TEMP, warn_t);
        put_reg(REG_REARM_TEMP, rearm_t);
        i_cfg_we <= 1'b0;
        cfg_capacity = cap;
        cfg_tcoef    = tcoef;
        cfg_rise     = rise[14:0];
        cfg_trip     = trip_t;
        cfg_warn     = warn_t;
        cfg_rearm    = rearm_t;
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_op(OP_OTHER, 1'b0);
        send_grid(1'b1, 16'd1600, 1'b0, 16'd0, 1'b0, 16'd0);
        send_grid(1'b1, 16'hffff, 1'b1, 16'hffff, 1'b0, 16'd0);
        send_grid(1'b1, 16'd0, 1'b1, 16'd14745, 1'b0, 16'd0);
        send_grid(1'b0, 16'd0, 1'b1, 16'd14746, 1'b0, 16'd0);
        send_grid(1'b0, 16'd0, 1'b1, 16'd15564, 1'b0, 16'd0);
        send_grid(1'b0, 16'd0, 1'b1, 16'd15565, 1'b0, 16'd0);
        send_grid(1'b0, 16'd0, 1'b1, 16'd0, 1'b0, 16'd0);
        // nothing present: carried values must be ignored
        send_grid(1'b0, 16'hffff, 1'b0, 16'hffff, 1'b0, 16'h7fff);
        // derate band between warning and trip
        send_grid(1'b0, 16'd0, 1'b1, 16'd16384, 1'b1, 16'd6500);
        // trip with load shed, ratio taken before the shed
        send_grid(1'b1, 16'd3200, 1'b0, 16'd0, 1'b1, 16'h7fff);
        send_grid(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 16'd5000);
        send_grid(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 16'h8000);
        send_weather(1'b1, 16'h7fff);
        send_weather(1'b0, 16'h8000);
        send_weather(1'b1, 16'h8000);
        send_weather(1'b1, 16'd1600);
        send_protection(1'b1, 1'b1);
        send_protection(1'b0, 1'b1);
        send_protection(1'b1, 1'b0);
        send_op(OP_MAINTENANCE, 1'b1);
        send_op(OP_MAINTENANCE, 1'b0);
        for (int k = OP_MAINTENANCE + 1; k < 8; k++) send_op(3'(k), 1'b1);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // minimum capacity, fastest step, full rise: core saturates at the top
        load_config(16'd0, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_weather(1'b1, 16'h7fff);
        send_grid(1'b1, 16'hffff, 1'b1, 16'd16384, 1'b1, 16'd0);
        send_op(OP_OTHER, 1'b0);
        send_op(OP_OTHER, 1'b0);
        send_protection(1'b1, 1'b1);
        send_op(OP_OTHER, 1'b0);
        send_protection(1'b1, 1'b0);
        repeat (6) send_event(random_event());
        wait_drained();

        // frozen core, no rise, trip and warning thresholds at the bottom
        load_config(16'hffff, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h7fff);
        send_grid(1'b1, 16'hffff, 1'b1, 16'd15000, 1'b1, 16'd100);
        send_grid(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 16'h8000);
        send_op(OP_OTHER, 1'b0);
        send_weather(1'b1, 16'h8000);
        repeat (6) send_event(random_event());
        wait_drained();

        // narrow derate band, half of the gap closed per step
        load_config(16'd16, 16'h8000, 16'd1, 16'd100, 16'd0, 16'hff9c);
        send_weather(1'b1, 16'd60);
        send_grid(1'b1, 16'd0, 1'b1, 16'd16384, 1'b1, 16'd90);
        send_grid(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 16'd99);
        send_grid(1'b1, 16'd16, 1'b0, 16'd0, 1'b1, 16'd150);
        send_grid(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 16'hff00);
        repeat (6) send_event(random_event());
        wait_drained();
    endtask

    task automatic test_random_telemetry();
        logic [15:0] warn;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                load_config(CAPACITY_RST, TIME_COEF_RST, 16'(RATED_RISE_RST),
                            TRIP_TEMP_RST, WARN_TEMP_RST, REARM_TEMP_RST);
            end else if ($urandom_range(0, 4) == 0) begin
                load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
            end else begin
                warn = 16'($urandom_range(3000, 7000));
                load_config(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(400, 4000)),
                            ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(300, 20000)),
                            16'($urandom), 16'(warn + $urandom_range(1, 2000)), warn,
                            16'(warn - $urandom_range(0, 3000)));
            end
            repeat (75) send_event(random_event());
            wait_drained();
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        @(posedge i_clk);
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
        burst_left = 1000;
        repeat (16) send_event(random_event());
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_telemetry();
        test_output_backpressure();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d telemetry events under %0d register settings,", events_sent,
                 settings_used + 1);
        $display("%0d step results compared, %0d mismatches", steps_checked, mismatch_count);
        if (mismatch_count == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase == '0) rx_mode <= 2'($urandom_range(0, 3));
        if (hold_seen != hold_seq) begin
            hold_seen     <= hold_seq;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_phase[4:2] != 3'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_thermal_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_steps.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_steps.pop_front();
                if (m_axis_tdata[15:0] !== want.core) begin
                    $error("core_temperature: expected %0d, got %0d", want.core,
                           $signed(m_axis_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[16] !== want.tripped) begin
                    $error("tripped: expected %0d, got %0d", want.tripped, m_axis_tdata[16]);
                    mismatch_count++;
                end
                if (m_axis_tdata[34:17] !== want.ratio) begin
                    $error("load_ratio: expected %0d, got %0d", want.ratio, m_axis_tdata[34:17]);
                    mismatch_count++;
                end
                if (m_axis_tdata[51:35] !== want.factor) begin
                    $error("throughput_factor: expected %0d, got %0d", want.factor,
                           m_axis_tdata[51:35]);
                    mismatch_count++;
                end
                steps_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped at %0d cycles with %0d results outstanding", cycle_count,
                     expected_steps.size());
            $display("testbench failed");
            $finish;
        end
    end

endmodule
